// ----- rtl/omni_odometry_integrator_defines.svh -----
// ----------------------------------------------------------------------------
// omni odometry integrator assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef OMNI_ODOMETRY_INTEGRATOR_DEFINES_SVH
`define OMNI_ODOMETRY_INTEGRATOR_DEFINES_SVH

// implication checked in the same cycle
`define OOI_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// implication checked in the next cycle
`define OOI_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/ooi_pkg.sv -----
// ----------------------------------------------------------------------------
// ooi_pkg
// shared types, constants and tables of the omni odometry integrator
// ----------------------------------------------------------------------------
package ooi_pkg;

    localparam int WHEELS  = 3;
    localparam int WHEEL_W = 2;
    localparam int ITER_W  = 5;
    localparam int ANG_W   = 27;
    localparam int VEC_W   = 34;

    localparam logic signed [ANG_W-1:0] HALF_TURN    = 27'sd11796480;
    localparam logic signed [ANG_W-1:0] FULL_TURN    = 27'sd23592960;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 27'sd5898240;
    localparam logic signed [VEC_W-1:0] CORDIC_START = 34'sd652032874;

    localparam logic OP_INTEGRATE = 1'b0;
    localparam logic OP_LOAD      = 1'b1;

    localparam logic [2:0] REG_WHEEL_A = 3'd0;
    localparam logic [2:0] REG_WHEEL_B = 3'd1;
    localparam logic [2:0] REG_WHEEL_C = 3'd2;
    localparam logic [2:0] REG_SCALE   = 3'd3;
    localparam logic [2:0] REG_GAIN    = 3'd4;

    typedef struct packed {
        logic               capture;
        logic               angle;
        logic               reduce;
        logic               fold;
        logic               rot;
        logic               round;
        logic               mac;
        logic               scale;
        logic               divide;
        logic               recip;
        logic               update;
        logic               load;
        logic               present;
        logic [ITER_W-1:0]  iter;
        logic [WHEEL_W-1:0] wheel;
    } cmd_t;

    typedef struct packed {
        logic in_range;
    } status_t;

    // arctangent of 2^-i in units of 2^-16 degree
    function automatic logic signed [ANG_W-1:0] atan_step(input logic [ITER_W-1:0] i);
        logic signed [ANG_W-1:0] a;
        case (i)
            5'd0:  a = 27'sd2949120;
            5'd1:  a = 27'sd1740967;
            5'd2:  a = 27'sd919879;
            5'd3:  a = 27'sd466945;
            5'd4:  a = 27'sd234379;
            5'd5:  a = 27'sd117304;
            5'd6:  a = 27'sd58666;
            5'd7:  a = 27'sd29335;
            5'd8:  a = 27'sd14668;
            5'd9:  a = 27'sd7334;
            5'd10: a = 27'sd3667;
            5'd11: a = 27'sd1833;
            5'd12: a = 27'sd917;
            5'd13: a = 27'sd458;
            5'd14: a = 27'sd229;
            5'd15: a = 27'sd115;
            5'd16: a = 27'sd57;
            5'd17: a = 27'sd29;
            5'd18: a = 27'sd14;
            5'd19: a = 27'sd7;
            5'd20: a = 27'sd4;
            5'd21: a = 27'sd2;
            5'd22: a = 27'sd1;
            default: a = 27'sd0;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/ooi_if.sv -----
// ----------------------------------------------------------------------------
// ooi channel interfaces
// valid/ready channels for update words and pose words
// ----------------------------------------------------------------------------
interface ooi_upd_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] dist_a;
    logic signed [15:0] dist_b;
    logic signed [15:0] dist_c;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [24:0] new_heading;

    modport source (output valid, op, dist_a, dist_b, dist_c, new_x, new_y, new_heading,
                    input ready);
    modport sink   (input valid, op, dist_a, dist_b, dist_c, new_x, new_y, new_heading,
                    output ready);
endinterface

interface ooi_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [24:0] heading;

    modport source (output valid, x_pos, y_pos, heading, input ready);
    modport sink   (input valid, x_pos, y_pos, heading, output ready);
endinterface

// ----- rtl/ooi_ctrl.sv -----
// ----------------------------------------------------------------------------
// ooi_ctrl
// sequencer for angle reduction, cordic, accumulation, pose update and pose load
// ----------------------------------------------------------------------------
module ooi_ctrl #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_op,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  ooi_pkg::status_t status,
    output ooi_pkg::cmd_t    cmd
);
    import ooi_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ANGLE   = 4'd1;
    localparam logic [3:0] S_REDUCE  = 4'd2;
    localparam logic [3:0] S_FOLD    = 4'd3;
    localparam logic [3:0] S_ROT     = 4'd4;
    localparam logic [3:0] S_ROUND   = 4'd5;
    localparam logic [3:0] S_MAC     = 4'd6;
    localparam logic [3:0] S_SCALE   = 4'd7;
    localparam logic [3:0] S_DIVIDE  = 4'd8;
    localparam logic [3:0] S_RECIP   = 4'd9;
    localparam logic [3:0] S_UPDATE  = 4'd10;
    localparam logic [3:0] S_LOAD    = 4'd11;
    localparam logic [3:0] S_PRESENT = 4'd12;

    localparam logic [ITER_W-1:0]  LAST_ITER  = ITER_W'(TRIG_ITERATIONS - 1);
    localparam logic [WHEEL_W-1:0] LAST_WHEEL = WHEEL_W'(WHEELS - 1);

    logic [3:0]         state_reg, state_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [WHEEL_W-1:0] wheel_reg, wheel_next;
    logic               out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        wheel_next     = wheel_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.iter       = iter_reg;
        cmd.wheel      = wheel_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    wheel_next  = '0;
                    state_next  = (in_op == OP_LOAD) ? S_LOAD : S_ANGLE;
                end
            end
            S_ANGLE:
            begin
                cmd.angle  = 1'b1;
                state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                if (status.in_range)
                begin
                    state_next = S_FOLD;
                end
                else
                begin
                    cmd.reduce = 1'b1;
                end
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                iter_next  = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.rot = 1'b1;
                if (iter_reg == LAST_ITER)
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                cmd.mac = 1'b1;
                if (wheel_reg == LAST_WHEEL)
                begin
                    state_next = S_SCALE;
                end
                else
                begin
                    wheel_next = wheel_reg + 1'b1;
                    state_next = S_ANGLE;
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                cmd.divide = 1'b1;
                state_next = S_RECIP;
            end
            S_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_PRESENT;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_PRESENT;
            end
            S_PRESENT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.present    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            wheel_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            wheel_reg     <= wheel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/ooi_datapath.sv -----
// ----------------------------------------------------------------------------
// ooi_datapath
// cordic, wheel accumulation, scaling and pose registers
// ----------------------------------------------------------------------------
module ooi_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  ooi_pkg::cmd_t      cmd,
    output ooi_pkg::status_t   status,
    input  logic signed [15:0] dist_a,
    input  logic signed [15:0] dist_b,
    input  logic signed [15:0] dist_c,
    input  logic signed [31:0] new_x,
    input  logic signed [31:0] new_y,
    input  logic signed [24:0] new_heading,
    input  logic signed [8:0]  wheel_a_angle,
    input  logic signed [8:0]  wheel_b_angle,
    input  logic signed [8:0]  wheel_c_angle,
    input  logic [16:0]        position_scale,
    input  logic [23:0]        turn_gain,
    output logic signed [31:0] x_pos,
    output logic signed [31:0] y_pos,
    output logic signed [24:0] heading
);
    import ooi_pkg::*;

    localparam logic [26:0] DIV_BIAS  = 27'd100663296;  // 3 * 2^25
    localparam logic [26:0] RECIP3    = 27'd89478485;   // floor(2^28 / 3)
    localparam logic signed [27:0] Q_BIAS = 28'sd33554432;

    // captured word
    logic signed [15:0] dist_reg [WHEELS];
    logic signed [31:0] new_x_reg, new_y_reg;
    logic signed [24:0] new_h_reg;

    // trig working registers
    logic signed [ANG_W-1:0] r_reg, z_reg;
    logic signed [VEC_W-1:0] vx_reg, vy_reg;
    logic                    neg_reg;
    logic signed [15:0]      c_reg, s_reg;

    // sums and products
    logic signed [VEC_W-1:0] sx_reg, sy_reg;
    logic signed [17:0]      sd_reg;
    logic signed [51:0]      px_reg, py_reg;
    logic signed [42:0]      ph_reg;
    logic [26:0]             u_reg;
    logic [25:0]             q0_reg;

    // pose
    logic signed [31:0] x_acc_reg, y_acc_reg;
    logic signed [24:0] h_acc_reg;
    logic signed [31:0] x_out_reg, y_out_reg;
    logic signed [24:0] h_out_reg;

    logic signed [8:0]       mount;
    logic signed [15:0]      dist_sel;
    logic signed [VEC_W-1:0] xs, ys, xr, yr;
    logic signed [31:0]      prod_c, prod_s;
    logic signed [51:0]      dx, dy;
    logic signed [VEC_W-1:0] xsum, ysum;
    logic signed [42:0]      t;
    logic [53:0]             recip_prod;
    logic [26:0]             rem;
    logic [25:0]             q;
    logic signed [27:0]      dh, h0, h1, h2;

    function automatic logic signed [15:0] sat16(input logic signed [VEC_W-1:0] v);
        if (v > 34'sd32767)
            return 16'sh7fff;
        else if (v < -34'sd32768)
            return -16'sh8000;
        else
            return v[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [VEC_W-1:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    assign status.in_range = (r_reg >= -HALF_TURN) && (r_reg < HALF_TURN);

    always_comb
    begin
        case (cmd.wheel)
            2'd0:    mount = wheel_a_angle;
            2'd1:    mount = wheel_b_angle;
            default: mount = wheel_c_angle;
        endcase
        dist_sel   = dist_reg[cmd.wheel];
        xs         = vx_reg >>> cmd.iter;
        ys         = vy_reg >>> cmd.iter;
        xr         = (vx_reg + 34'sd16384) >>> 15;
        yr         = (vy_reg + 34'sd16384) >>> 15;
        prod_c     = c_reg * dist_sel;
        prod_s     = s_reg * dist_sel;
        dx         = (px_reg + 52'sd1073741824) >>> 31;
        dy         = (py_reg + 52'sd1073741824) >>> 31;
        xsum       = {{2{x_acc_reg[31]}}, x_acc_reg} + dx[VEC_W-1:0];
        ysum       = {{2{y_acc_reg[31]}}, y_acc_reg} + dy[VEC_W-1:0];
        t          = (ph_reg + 43'sd98304) >>> 16;
        recip_prod = u_reg * RECIP3;
        rem        = u_reg - 27'(q0_reg) * 27'd3;
        q          = q0_reg + ((rem >= 27'd3) ? 26'd1 : 26'd0);
        dh         = $signed({2'b00, q}) - Q_BIAS;
        h0         = {{3{h_acc_reg[24]}}, h_acc_reg} + dh;
        h1         = (h0 > 28'sd11796480) ? h0 - 28'sd23592960 : h0;
        h2         = (h1 < -28'sd11796480) ? h1 + 28'sd23592960 : h1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dist_reg[0] <= dist_a;
            dist_reg[1] <= dist_b;
            dist_reg[2] <= dist_c;
            new_x_reg   <= new_x;
            new_y_reg   <= new_y;
            new_h_reg   <= new_heading;
            sx_reg      <= '0;
            sy_reg      <= '0;
            sd_reg      <= '0;
        end
        if (cmd.angle)
        begin
            r_reg <= {{2{mount[8]}}, mount, 16'd0} + {{2{h_acc_reg[24]}}, h_acc_reg};
        end
        if (cmd.reduce)
        begin
            r_reg <= (r_reg >= HALF_TURN) ? r_reg - FULL_TURN : r_reg + FULL_TURN;
        end
        if (cmd.fold)
        begin
            vx_reg <= CORDIC_START;
            vy_reg <= '0;
            if (r_reg > QUARTER_TURN)
            begin
                z_reg   <= r_reg - HALF_TURN;
                neg_reg <= 1'b1;
            end
            else if (r_reg < -QUARTER_TURN)
            begin
                z_reg   <= r_reg + HALF_TURN;
                neg_reg <= 1'b1;
            end
            else
            begin
                z_reg   <= r_reg;
                neg_reg <= 1'b0;
            end
        end
        if (cmd.rot)
        begin
            if (z_reg >= 0)
            begin
                vx_reg <= vx_reg - ys;
                vy_reg <= vy_reg + xs;
                z_reg  <= z_reg - atan_step(cmd.iter);
            end
            else
            begin
                vx_reg <= vx_reg + ys;
                vy_reg <= vy_reg - xs;
                z_reg  <= z_reg + atan_step(cmd.iter);
            end
        end
        if (cmd.round)
        begin
            c_reg <= sat16(neg_reg ? -xr : xr);
            s_reg <= sat16(neg_reg ? -yr : yr);
        end
        if (cmd.mac)
        begin
            sx_reg <= sx_reg + {{2{prod_c[31]}}, prod_c};
            sy_reg <= sy_reg - {{2{prod_s[31]}}, prod_s};
            sd_reg <= sd_reg + {{2{dist_sel[15]}}, dist_sel};
        end
        if (cmd.scale)
        begin
            px_reg <= sx_reg * $signed({1'b0, position_scale});
            py_reg <= sy_reg * $signed({1'b0, position_scale});
            ph_reg <= sd_reg * $signed({1'b0, turn_gain});
        end
        if (cmd.divide)
        begin
            // bias keeps the floor division by three on a positive value
            u_reg <= t[26:0] + DIV_BIAS;
        end
        if (cmd.recip)
        begin
            q0_reg <= recip_prod[53:28];
        end
        if (cmd.present)
        begin
            x_out_reg <= x_acc_reg;
            y_out_reg <= y_acc_reg;
            h_out_reg <= h_acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_acc_reg <= '0;
            y_acc_reg <= '0;
            h_acc_reg <= '0;
        end
        else if (cmd.load)
        begin
            x_acc_reg <= new_x_reg;
            y_acc_reg <= new_y_reg;
            h_acc_reg <= new_h_reg;
        end
        else
        begin
            if (cmd.divide)
            begin
                x_acc_reg <= sat32(xsum);
                y_acc_reg <= sat32(ysum);
            end
            if (cmd.update)
            begin
                h_acc_reg <= h2[24:0];
            end
        end
    end

    assign x_pos   = x_out_reg;
    assign y_pos   = y_out_reg;
    assign heading = h_out_reg;

endmodule

// ----- rtl/omni_odometry_integrator.sv -----
// ----------------------------------------------------------------------------
// omni_odometry_integrator
// dead-reckoning pose integrator for a three-wheel omni base
// ----------------------------------------------------------------------------
// Each word on upd either integrates the travel of the three wheels (op 0) or
// loads the pose (op 1), and each word returns one pose word on pose. An
// integrate word runs the three wheels one after another through a single
// iterative cordic: per wheel it forms the angle, reduces it into the half-turn
// range, folds it, runs the rotation steps, rounds and accumulates; then come
// scale, divide, reciprocal and heading update, and a present step hands out
// the pose. A load word is captured, loaded and presented. A new word is taken
// while the previous pose still waits on pose. Registers sit on an APB port at
// byte address 4 * index.
// ----------------------------------------------------------------------------
module omni_odometry_integrator #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    ooi_upd_if.sink     upd,
    ooi_pose_if.source  pose,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ooi_pkg::*;

    // configuration registers
    logic signed [8:0] wheel_a_reg, wheel_b_reg, wheel_c_reg;
    logic [16:0]       scale_reg;
    logic [23:0]       gain_reg;

    cmd_t    cmd;
    status_t status;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    // register writes, addresses past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_a_reg <= -9'sd60;
            wheel_b_reg <= 9'sd180;
            wheel_c_reg <= 9'sd60;
            scale_reg   <= 17'd41615;
            gain_reg    <= 24'd2532350;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WHEEL_A: wheel_a_reg <= pwdata[8:0];
                REG_WHEEL_B: wheel_b_reg <= pwdata[8:0];
                REG_WHEEL_C: wheel_c_reg <= pwdata[8:0];
                REG_SCALE:   scale_reg   <= pwdata[16:0];
                REG_GAIN:    gain_reg    <= pwdata[23:0];
                default:     ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_index)
            REG_WHEEL_A: prdata = {23'd0, wheel_a_reg};
            REG_WHEEL_B: prdata = {23'd0, wheel_b_reg};
            REG_WHEEL_C: prdata = {23'd0, wheel_c_reg};
            REG_SCALE:   prdata = {15'd0, scale_reg};
            REG_GAIN:    prdata = {8'd0, gain_reg};
            default:     prdata = '0;
        endcase
    end

    // sequencer: one word at a time, pose register parts the two sides
    ooi_ctrl #(
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (upd.valid),
        .in_op     (upd.op),
        .in_ready  (upd.ready),
        .out_valid (pose.valid),
        .out_ready (pose.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and pose state
    ooi_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .dist_a         (upd.dist_a),
        .dist_b         (upd.dist_b),
        .dist_c         (upd.dist_c),
        .new_x          (upd.new_x),
        .new_y          (upd.new_y),
        .new_heading    (upd.new_heading),
        .wheel_a_angle  (wheel_a_reg),
        .wheel_b_angle  (wheel_b_reg),
        .wheel_c_angle  (wheel_c_reg),
        .position_scale (scale_reg),
        .turn_gain      (gain_reg),
        .x_pos          (pose.x_pos),
        .y_pos          (pose.y_pos),
        .heading        (pose.heading)
    );

endmodule

// ----- rtl/ooi_checker.sv -----
// ----------------------------------------------------------------------------
// ooi_checker
// port-level assertions for the omni odometry integrator
// ----------------------------------------------------------------------------
`include "omni_odometry_integrator_defines.svh"

module ooi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               upd_valid,
    input logic               upd_ready,
    input logic               pose_valid,
    input logic               pose_ready,
    input logic signed [31:0] x_pos,
    input logic signed [31:0] y_pos,
    input logic signed [24:0] heading,
    input logic               pready
);

    // a stalled pose word stays up
    `OOI_ASSERT_NEXT(a_pose_hold, pose_valid && !pose_ready, pose_valid, "pose word dropped")

    // a stalled pose word keeps its value
    `OOI_ASSERT_NEXT(a_pose_stable, pose_valid && !pose_ready,
        $stable(x_pos) && $stable(y_pos) && $stable(heading), "pose word changed")

    // one word at a time: taking a word closes the input for the next cycle
    `OOI_ASSERT_NEXT(a_one_word, upd_valid && upd_ready, !upd_ready, "second word taken")

    // the register port never waits
    `OOI_ASSERT_NOW(a_pready, 1'b1, pready, "pready low")

endmodule

bind omni_odometry_integrator ooi_checker u_ooi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd_valid  (upd.valid),
    .upd_ready  (upd.ready),
    .pose_valid (pose.valid),
    .pose_ready (pose.ready),
    .x_pos      (pose.x_pos),
    .y_pos      (pose.y_pos),
    .heading    (pose.heading),
    .pready     (pready)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni odometry integrator testbench
// drives update words over valid/ready with random idling and stalls, writes
// the mount angles, scale and turn gain over apb between phases, and checks
// every pose word against a cycle-free model of the pose arithmetic or a typed-in pose
// ----------------------------------------------------------------------------
module tb;
    import ooi_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ooi_upd_if  upd ();
    ooi_pose_if pose ();

    omni_odometry_integrator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd     (upd.sink),
        .pose    (pose.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // one pose word as it should come out
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [24:0] h;
    } pose_t;

    // one row of the directed table; chk set where the pose is typed in
    typedef struct {
        logic               op;
        logic signed [15:0] da;
        logic signed [15:0] db;
        logic signed [15:0] dc;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [24:0] nh;
        bit                 chk;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [24:0] eh;
    } row_t;

    // model copy of the configuration and the pose
    logic signed [8:0]  mount_angle [3];
    logic        [16:0] pos_scale;
    logic        [23:0] yaw_gain;
    longint             pose_x;
    longint             pose_y;
    longint             pose_h;

    pose_t  pose_queue[$];
    int     err_count;
    longint cycle_count;
    int     send_idle_pct;
    int     recv_stall_pct;

    localparam longint CYCLE_LIMIT = 64'd3000000;
    localparam longint HALF_T = 64'd11796480;
    localparam longint FULL_T = 64'd23592960;

    // ------------------------------------------------------------------------
    // clock, reset, cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("omni_odometry_integrator regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // model arithmetic
    // ------------------------------------------------------------------------
    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    // arithmetic shift is floor division by a power of two
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // cos and sin in q1.15 of an angle in 2^-16 degree
    task automatic cordic_cos_sin(input longint ang, output longint c, output longint s);
        longint r, vx, vy, z, xs, ys;
        bit     flip;
        r    = ang - FULL_T * floor_div(ang + HALF_T, FULL_T);
        flip = 1'b0;
        if (r > 64'sd5898240)
        begin
            r -= HALF_T;
            flip = 1'b1;
        end
        else if (r < -64'sd5898240)
        begin
            r += HALF_T;
            flip = 1'b1;
        end
        z  = r;
        vx = 64'd652032874;
        vy = 0;
        for (int i = 0; i < 16; i++)
        begin
            xs = shr_floor(vx, i);
            ys = shr_floor(vy, i);
            if (z >= 0)
            begin
                vx -= ys;
                vy += xs;
                z  -= longint'(atan_step(i[4:0]));
            end
            else
            begin
                vx += ys;
                vy -= xs;
                z  += longint'(atan_step(i[4:0]));
            end
        end
        vx = shr_floor(vx + 16384, 15);
        vy = shr_floor(vy + 16384, 15);
        if (flip)
        begin
            vx = -vx;
            vy = -vy;
        end
        c = clamp(vx, -32768, 32767);
        s = clamp(vy, -32768, 32767);
    endtask

    // advance the model pose by one update word and return the new pose
    task automatic advance_pose(input row_t w, output pose_t p);
        longint sx, sy, sd, d, c, s, dh, hn;
        logic signed [24:0] h25;
        if (w.op == OP_LOAD)
        begin
            pose_x = w.nx;
            pose_y = w.ny;
            pose_h = w.nh;
        end
        else
        begin
            sx = 0;
            sy = 0;
            sd = 0;
            for (int k = 0; k < 3; k++)
            begin
                d = (k == 0) ? w.da : ((k == 1) ? w.db : w.dc);
                cordic_cos_sin(longint'(mount_angle[k]) * 65536 + pose_h, c, s);
                sx += c * d;
                sy -= s * d;
                sd += d;
            end
            pose_x = clamp(pose_x + shr_floor(sx * longint'(pos_scale) + (64'd1 << 30), 31),
                           -64'd2147483648, 64'd2147483647);
            pose_y = clamp(pose_y + shr_floor(sy * longint'(pos_scale) + (64'd1 << 30), 31),
                           -64'd2147483648, 64'd2147483647);
            dh = floor_div(sd * longint'(yaw_gain) + 98304, 196608);
            hn = pose_h + dh;
            if (hn > HALF_T)
                hn -= FULL_T;
            if (hn < -HALF_T)
                hn += FULL_T;
            h25    = hn[24:0];
            pose_h = h25;
        end
        p.x = pose_x[31:0];
        p.y = pose_y[31:0];
        p.h = pose_h[24:0];
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                 want);
        err_count++;
    endtask

    initial
    begin
        pose.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pose.valid && pose.ready)
            begin
                if (pose_queue.size() == 0)
                    report_mismatch("unexpected pose word", 0, 0);
                else
                begin
                    pose_t e;
                    e = pose_queue.pop_front();
                    if (pose.x_pos !== e.x)
                        report_mismatch("x_pos", pose.x_pos, e.x);
                    if (pose.y_pos !== e.y)
                        report_mismatch("y_pos", pose.y_pos, e.y);
                    if (pose.heading !== e.h)
                        report_mismatch("heading", pose.heading, e.h);
                end
            end
            pose.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_WHEEL_A: mount_angle[0] = val[8:0];
            REG_WHEEL_B: mount_angle[1] = val[8:0];
            REG_WHEEL_C: mount_angle[2] = val[8:0];
            REG_SCALE:   pos_scale = val[16:0];
            default:     yaw_gain = val[23:0];
        endcase
    endtask

    // send one update word, record its expected pose at acceptance
    task automatic send_word(input row_t w);
        pose_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            upd.valid <= 1'b0;
            @(posedge clk);
        end
        upd.valid       <= 1'b1;
        upd.op          <= w.op;
        upd.dist_a      <= w.da;
        upd.dist_b      <= w.db;
        upd.dist_c      <= w.dc;
        upd.new_x       <= w.nx;
        upd.new_y       <= w.ny;
        upd.new_heading <= w.nh;
        do @(posedge clk); while (!upd.ready);
        advance_pose(w, p);
        if (w.chk && (p.x !== w.ex || p.y !== w.ey || p.h !== w.eh))
        begin
            // typed-in value wins over the model
            p.x = w.ex;
            p.y = w.ey;
            p.h = w.eh;
        end
        pose_queue.push_back(p);
    endtask

    // wait until every pose word is back, then let the block settle
    task automatic drain();
        upd.valid <= 1'b0;
        while (pose_queue.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic row_t rand_word();
        row_t w;
        int   sel;
        w     = '{default: '0};
        w.op  = ($urandom_range(99) < 15) ? OP_LOAD : OP_INTEGRATE;
        sel   = $urandom_range(9);
        w.da  = (sel == 0) ? $urandom() : $signed(16'($urandom_range(4000))) - 2000;
        w.db  = (sel == 1) ? $urandom() : $signed(16'($urandom_range(4000))) - 2000;
        w.dc  = (sel == 2) ? $urandom() : $signed(16'($urandom_range(4000))) - 2000;
        w.nx  = (sel < 3) ? $urandom() : $signed(32'($urandom_range(2000000))) - 1000000;
        w.ny  = (sel > 6) ? $urandom() : $signed(32'($urandom_range(2000000))) - 1000000;
        // mostly in range, sometimes any 25-bit value
        w.nh  = (sel == 5) ? 25'($urandom()) : 25'($urandom_range(23592960)) - 25'sd11796480;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // directed table: extremes, load, wrap and saturation cases
    // ------------------------------------------------------------------------
    row_t dir_rows[] = '{
        // load zero pose, typed in
        '{OP_LOAD, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
        // no travel keeps the pose
        '{OP_INTEGRATE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
        // extremes of travel
        '{OP_INTEGRATE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 0, 0, 0},
        '{OP_INTEGRATE, -16'sh8000, -16'sh8000, -16'sh8000, 0, 0, 0, 0, 0, 0, 0},
        '{OP_INTEGRATE, 16'sh7fff, -16'sh8000, 16'sh1234, -1, -1, -1, 0, 0, 0, 0},
        // load extremes, typed in
        '{OP_LOAD, 5, 6, 7, 32'sh7fffffff, -32'sh80000000, 25'sd11796480, 1,
          32'sh7fffffff, -32'sh80000000, 25'sd11796480},
        // saturation at the top and bottom
        '{OP_INTEGRATE, 16'sh7fff, -16'sh8000, 0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_INTEGRATE, -16'sh8000, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 0, 0, 0},
        '{OP_LOAD, 0, 0, 0, -32'sh80000000, 32'sh7fffffff, -25'sd11796480, 1,
          -32'sh80000000, 32'sh7fffffff, -25'sd11796480},
        '{OP_INTEGRATE, -16'sh8000, -16'sh8000, -16'sh8000, 0, 0, 0, 0, 0, 0, 0},
        // out-of-range loaded heading, wrapped by the next integrate
        '{OP_LOAD, 0, 0, 0, 100, -100, 25'sh0ffffff, 1, 100, -100, 25'sh0ffffff},
        '{OP_INTEGRATE, 100, 200, 300, 0, 0, 0, 0, 0, 0, 0},
        '{OP_LOAD, 0, 0, 0, 0, 0, -25'sh1000000, 1, 0, 0, -25'sh1000000},
        '{OP_INTEGRATE, -100, 0, 50, 0, 0, 0, 0, 0, 0, 0},
        // near the half turn, wrap upward and downward
        '{OP_LOAD, 0, 0, 0, 0, 0, 25'sd11790000, 1, 0, 0, 25'sd11790000},
        '{OP_INTEGRATE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 0, 0, 0},
        '{OP_LOAD, 0, 0, 0, 0, 0, -25'sd11790000, 1, 0, 0, -25'sd11790000},
        '{OP_INTEGRATE, -16'sh8000, -16'sh8000, -16'sh8000, 0, 0, 0, 0, 0, 0, 0},
        // load ignores the travel fields
        '{OP_LOAD, 16'sh7fff, -16'sh8000, 16'sh5555, 0, 0, 0, 1, 0, 0, 0},
        '{OP_INTEGRATE, 1, -1, 1, 32'sh7fffffff, -1, 25'sh1555555, 0, 0, 0, 0}
    };

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        row_t w;
        int   n;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        upd.valid       = 1'b0;
        upd.op          = OP_INTEGRATE;
        upd.dist_a      = '0;
        upd.dist_b      = '0;
        upd.dist_c      = '0;
        upd.new_x       = '0;
        upd.new_y       = '0;
        upd.new_heading = '0;
        err_count       = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        mount_angle[0]  = -9'sd60;
        mount_angle[1]  = 9'sd180;
        mount_angle[2]  = 9'sd60;
        pos_scale       = 17'd41615;
        yaw_gain        = 24'd2532350;
        pose_x          = 0;
        pose_y          = 0;
        pose_h          = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at reset settings, no idling
        foreach (dir_rows[i])
            send_word(dir_rows[i]);
        drain();

        // random phases across settings and idling patterns
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
                4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            case (ph)
                1:
                begin
                    // upper extremes
                    apb_write(REG_WHEEL_A, 32'd180);
                    apb_write(REG_WHEEL_B, 32'd180);
                    apb_write(REG_WHEEL_C, 32'd180);
                    apb_write(REG_SCALE, 32'd131071);
                    apb_write(REG_GAIN, 32'd16777215);
                end
                2:
                begin
                    // lower extremes
                    apb_write(REG_WHEEL_A, 32'(-180));
                    apb_write(REG_WHEEL_B, 32'(-180));
                    apb_write(REG_WHEEL_C, 32'(-180));
                    apb_write(REG_SCALE, 32'd0);
                    apb_write(REG_GAIN, 32'd0);
                end
                0: ;
                default:
                begin
                    // any nine-bit angle on wheels a and b, mount beyond the half turn included
                    apb_write(REG_WHEEL_A, $urandom());
                    apb_write(REG_WHEEL_B, $urandom());
                    apb_write(REG_WHEEL_C, 32'($signed(9'($urandom_range(360))) - 180));
                    apb_write(REG_SCALE, $urandom());
                    apb_write(REG_GAIN, $urandom());
                end
            endcase
            n = (ph == 1 || ph == 2) ? 60 : 100;
            for (int k = 0; k < n; k++)
            begin
                w = rand_word();
                send_word(w);
            end
            drain();
        end

        if (err_count == 0)
            $display("omni_odometry_integrator regression: pass");
        else
            $display("omni_odometry_integrator regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ooi_pkg.sv
rtl/ooi_if.sv
rtl/ooi_ctrl.sv
rtl/ooi_datapath.sv
rtl/omni_odometry_integrator.sv
rtl/ooi_checker.sv
tb/tb.sv
